// ----- hdl/ipsd_pkg.sv -----
package ipsd_pkg;

  localparam int MAX_MESSAGE_BITS = 64;

  localparam int BURST_W = 16;
  localparam int SLOT_W  = 16;
  localparam int PPO_W   = 8;
  localparam int LEN_W   = 7;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BURST_W-1:0] BURST_RESET = 16'd1250;
  localparam logic [SLOT_W-1:0]  SLOT_RESET  = 16'd6250;
  localparam logic [PPO_W-1:0]   PPO_RESET   = 8'd8;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd51;
  localparam logic [LEN_W-1:0]   MIN_LEN     = 7'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPO        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN    = 2'd3;

  // dividend 2*gap + slot, divisor 2*slot
  localparam int DVD_W    = TIME_W + 2;
  localparam int DVS_W    = SLOT_W + 1;
  localparam int DIV_BITS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  typedef struct packed {
    logic [BURST_W-1:0] burst_gap_ticks;
    logic [SLOT_W-1:0]  slot_ticks;
    logic [PPO_W-1:0]   pulses_per_one;
    logic [LEN_W-1:0]   msg_len;
  } ipsd_cfg_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_NOP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ZEROS,
    OP_PULSE,
    OP_EMIT
  } ipsd_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_SHORT_GAP,
    COND_SLOT_ZERO,
    COND_DIV_MORE
  } ipsd_cond_t;

  typedef logic [2:0] ipsd_step_t;

  localparam ipsd_step_t STEP_WAIT     = 3'd0;
  localparam ipsd_step_t STEP_CLASS    = 3'd1;
  localparam ipsd_step_t STEP_DIV_INIT = 3'd2;
  localparam ipsd_step_t STEP_DIV_STEP = 3'd3;
  localparam ipsd_step_t STEP_ZEROS    = 3'd4;
  localparam ipsd_step_t STEP_PULSE    = 3'd5;
  localparam ipsd_step_t STEP_EMIT     = 3'd6;

  typedef struct packed {
    ipsd_op_t   op;
    ipsd_cond_t cond;
    ipsd_step_t target;
  } ipsd_ctl_t;

  typedef struct packed {
    logic hold;
    logic short_gap;
    logic slot_zero;
    logic div_more;
  } ipsd_status_t;

  function automatic ipsd_ctl_t ipsd_rom(input ipsd_step_t step);
    ipsd_ctl_t w;
    case (step)
      STEP_WAIT:     w = '{OP_WAIT,     COND_NEVER,     STEP_WAIT};
      STEP_CLASS:    w = '{OP_NOP,      COND_SHORT_GAP, STEP_PULSE};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_SLOT_ZERO, STEP_ZEROS};
      STEP_DIV_STEP: w = '{OP_DIV_STEP, COND_DIV_MORE,  STEP_DIV_STEP};
      STEP_ZEROS:    w = '{OP_ZEROS,    COND_ALWAYS,    STEP_EMIT};
      STEP_PULSE:    w = '{OP_PULSE,    COND_NEVER,     STEP_EMIT};
      STEP_EMIT:     w = '{OP_EMIT,     COND_ALWAYS,    STEP_WAIT};
      default:       w = '{OP_NOP,      COND_ALWAYS,    STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/ipsd_seq.sv -----
module ipsd_seq
  import ipsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ipsd_status_t status,
  output ipsd_ctl_t    ctl
);

  ipsd_step_t step_r;
  ipsd_step_t step_nxt;
  logic       take_jump;

  assign ctl = ipsd_rom(step_r);

  always_comb begin
    case (ctl.cond)
      COND_NEVER:     take_jump = 1'b0;
      COND_ALWAYS:    take_jump = 1'b1;
      COND_SHORT_GAP: take_jump = status.short_gap;
      COND_SLOT_ZERO: take_jump = status.slot_zero;
      COND_DIV_MORE:  take_jump = status.div_more;
      default:        take_jump = 1'b0;
    endcase
    if (status.hold) begin
      step_nxt = step_r;
    end else if (take_jump) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- hdl/ipsd_datapath.sv -----
module ipsd_datapath
  import ipsd_pkg::*;
#(
  parameter int MaxMessageBits = MAX_MESSAGE_BITS,
  localparam int CntW = $clog2(MaxMessageBits + 1),
  localparam int IdxW = $clog2(MaxMessageBits)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ipsd_ctl_t                 ctl,
  input  ipsd_cfg_t                 cfg,
  output ipsd_status_t              status,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TIME_W-1:0]         in_edge_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CntW-1:0]           out_bits_held,
  output logic [MaxMessageBits-1:0] out_message_bits,
  output logic                      out_message_done,
  output logic                      out_header_rejected
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxMessageBits);

  logic [TIME_W-1:0]         last_r, last_nxt;
  logic [TIME_W-1:0]         gap_r, gap_nxt;
  logic [PPO_W-1:0]          tally_r, tally_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic [MaxMessageBits-1:0] store_r, store_nxt;
  logic                      done_seen_r, done_seen_nxt;
  logic [DVS_W-1:0]          rem_r, rem_nxt;
  logic [DVD_W-1:0]          dvd_r, dvd_nxt;
  logic [DIV_CNT_W-1:0]      divcnt_r, divcnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CntW-1:0]           out_held_r, out_held_nxt;
  logic [MaxMessageBits-1:0] out_bits_r, out_bits_nxt;
  logic                      out_done_r, out_done_nxt;
  logic                      out_rej_r, out_rej_nxt;

  logic [LEN_W-1:0] len_clamp;
  logic [CntW-1:0]  len;
  logic [CntW-1:0]  space;
  logic [DVS_W-1:0] divisor;
  logic [DVS_W:0]   rem_sh;
  logic [CntW-1:0]  zeros;
  logic [PPO_W-1:0] tally_inc;
  logic             out_blocked;
  logic             rej;
  logic [CntW-1:0]  cnt_fin;

  always_comb begin
    if (cfg.msg_len < MIN_LEN) begin
      len_clamp = MIN_LEN;
    end else if (cfg.msg_len > MaxLen) begin
      len_clamp = MaxLen;
    end else begin
      len_clamp = cfg.msg_len;
    end
  end

  assign len         = CntW'(len_clamp);
  assign space       = (cnt_r < len) ? (len - cnt_r) : '0;
  assign divisor     = {cfg.slot_ticks, 1'b0};
  assign rem_sh      = {rem_r, dvd_r[DVD_W-1]};
  assign tally_inc   = tally_r + PPO_W'(1);
  assign out_blocked = out_valid_r && out_stall;
  assign rej         = (cnt_r == CntW'(2)) && (store_r[1:0] != 2'b01);
  assign cnt_fin     = rej ? '0 : cnt_r;

  always_comb begin
    if (cfg.slot_ticks == '0) begin
      zeros = space;
    end else if (dvd_r > DVD_W'(space)) begin
      zeros = space;
    end else begin
      zeros = CntW'(dvd_r);
    end
  end

  assign in_stall         = (ctl.op != OP_WAIT);
  assign status.hold      = ((ctl.op == OP_WAIT) && !in_valid) ||
                            ((ctl.op == OP_EMIT) && out_blocked);
  assign status.short_gap = gap_r < TIME_W'(cfg.burst_gap_ticks);
  assign status.slot_zero = (cfg.slot_ticks == '0);
  assign status.div_more  = (divcnt_r != DIV_CNT_W'(1));

  always_comb begin
    last_nxt      = last_r;
    gap_nxt       = gap_r;
    tally_nxt     = tally_r;
    cnt_nxt       = cnt_r;
    store_nxt     = store_r;
    done_seen_nxt = done_seen_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    divcnt_nxt    = divcnt_r;
    out_held_nxt  = out_held_r;
    out_bits_nxt  = out_bits_r;
    out_done_nxt  = out_done_r;
    out_rej_nxt   = out_rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (ctl.op)
      OP_WAIT: begin
        if (in_valid) begin
          last_nxt = in_edge_time;
          gap_nxt  = in_edge_time - last_r;
          if (done_seen_r) begin
            cnt_nxt       = '0;
            store_nxt     = '0;
            done_seen_nxt = 1'b0;
          end
        end
      end
      OP_DIV_INIT: begin
        dvd_nxt    = {1'b0, gap_r, 1'b0} + DVD_W'(cfg.slot_ticks);
        rem_nxt    = '0;
        divcnt_nxt = DIV_CNT_W'(DIV_BITS);
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem_nxt = DVS_W'(rem_sh - {1'b0, divisor});
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DVS_W-1:0];
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        end
        divcnt_nxt = divcnt_r - DIV_CNT_W'(1);
      end
      OP_ZEROS: begin
        cnt_nxt = cnt_r + zeros;
      end
      OP_PULSE: begin
        if (tally_inc == cfg.pulses_per_one) begin
          tally_nxt = '0;
          if (space != '0) begin
            store_nxt[cnt_r[IdxW-1:0]] = 1'b1;
            cnt_nxt = cnt_r + CntW'(1);
          end
        end else begin
          tally_nxt = tally_inc;
        end
      end
      OP_EMIT: begin
        if (!out_blocked) begin
          cnt_nxt       = cnt_fin;
          store_nxt     = rej ? '0 : store_r;
          done_seen_nxt = (cnt_fin >= len);
          out_held_nxt  = cnt_fin;
          out_bits_nxt  = rej ? '0 : store_r;
          out_done_nxt  = (cnt_fin >= len);
          out_rej_nxt   = rej;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      tally_r     <= '0;
      cnt_r       <= '0;
      store_r     <= '0;
      done_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      tally_r     <= tally_nxt;
      cnt_r       <= cnt_nxt;
      store_r     <= store_nxt;
      done_seen_r <= done_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r      <= gap_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    divcnt_r   <= divcnt_nxt;
    out_held_r <= out_held_nxt;
    out_bits_r <= out_bits_nxt;
    out_done_r <= out_done_nxt;
    out_rej_r  <= out_rej_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_bits_held       = out_held_r;
  assign out_message_bits    = out_bits_r;
  assign out_message_done    = out_done_r;
  assign out_header_rejected = out_rej_r;

endmodule

// ----- hdl/ir_pulse_slot_decoder.sv -----
// Flow: a short-gap edge goes from acceptance through the class and pulse steps to emit;
// a long-gap edge first passes the 34-step restoring divide for the zero-slot count.
// A slot of zero skips the divide. One item is in work at a time: in_stall stays high
// until the item is emitted, and the emit step waits while out_stall holds the output.
// Reset: synchronous, active-low rst_n clears the sequencer, decoder state and output
// valid, and loads the configuration registers with their defaults.
module ir_pulse_slot_decoder
  import ipsd_pkg::*;
#(
  parameter int MaxMessageBits = MAX_MESSAGE_BITS,
  localparam int CntW = $clog2(MaxMessageBits + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TIME_W-1:0]         in_edge_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CntW-1:0]           out_bits_held,
  output logic [MaxMessageBits-1:0] out_message_bits,
  output logic                      out_message_done,
  output logic                      out_header_rejected
);

  ipsd_cfg_t    cfg_r;
  ipsd_cfg_t    cfg_nxt;
  ipsd_ctl_t    ctl;
  ipsd_status_t status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_BURST_GAP: cfg_nxt.burst_gap_ticks = cfg_wdata[BURST_W-1:0];
        REG_SLOT:      cfg_nxt.slot_ticks      = cfg_wdata[SLOT_W-1:0];
        REG_PPO:       cfg_nxt.pulses_per_one  = cfg_wdata[PPO_W-1:0];
        REG_MSG_LEN:   cfg_nxt.msg_len         = cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{BURST_RESET, SLOT_RESET, PPO_RESET, LEN_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ipsd_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  ipsd_datapath #(
    .MaxMessageBits (MaxMessageBits)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .cfg                 (cfg_r),
    .status              (status),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_edge_time        (in_edge_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bits_held       (out_bits_held),
    .out_message_bits    (out_message_bits),
    .out_message_done    (out_message_done),
    .out_header_rejected (out_header_rejected)
  );

endmodule

// ----- dv/tb_ir_pulse_slot_decoder.sv -----
module tb_ir_pulse_slot_decoder;
  import ipsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LEN_W-1:0]            bits_held;
    logic [MAX_MESSAGE_BITS-1:0] message_bits;
    logic                        message_done;
    logic                        header_rejected;
  } slot_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [TIME_W-1:0]         in_edge_time = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LEN_W-1:0]          out_bits_held;
  logic [MAX_MESSAGE_BITS-1:0] out_message_bits;
  logic                      out_message_done;
  logic                      out_header_rejected;

  ir_pulse_slot_decoder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_edge_time        (in_edge_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bits_held       (out_bits_held),
    .out_message_bits    (out_message_bits),
    .out_message_done    (out_message_done),
    .out_header_rejected (out_header_rejected)
  );

  always #6 clk = ~clk;

  // register shadows
  logic [BURST_W-1:0] reg_burst_gap = BURST_RESET;
  logic [SLOT_W-1:0]  reg_slot      = SLOT_RESET;
  logic [PPO_W-1:0]   reg_ppo       = PPO_RESET;
  logic [LEN_W-1:0]   reg_msg_len   = LEN_RESET;

  // decoder state
  logic [TIME_W-1:0]           dec_last_time = '0;
  logic [PPO_W-1:0]            dec_tally     = '0;
  logic [LEN_W-1:0]            dec_count     = '0;
  logic [MAX_MESSAGE_BITS-1:0] dec_store     = '0;
  logic                        dec_done_seen = 1'b0;

  slot_result_t      pending_results[$];
  logic [TIME_W-1:0] edge_clock = '0;
  int unsigned       items_sent = 0;
  int unsigned       stall_left = 0;
  bit                sender_idle = 1'b1;
  bit                receiver_idle = 1'b1;
  bit                failed = 1'b0;

  function automatic void decode_edge(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] gap;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  room;
    logic [63:0]       zeros;
    slot_result_t      r;
    gap = now - dec_last_time;
    if (reg_msg_len < MIN_LEN) eff_len = MIN_LEN;
    else if (reg_msg_len > MAX_MESSAGE_BITS) eff_len = LEN_W'(MAX_MESSAGE_BITS);
    else eff_len = reg_msg_len;
    if (dec_done_seen) begin
      dec_count = '0;
      dec_store = '0;
      dec_done_seen = 1'b0;
    end
    room = (dec_count < eff_len) ? eff_len - dec_count : '0;
    r.header_rejected = 1'b0;
    if (gap < TIME_W'(reg_burst_gap)) begin
      dec_tally = dec_tally + 1'b1;
      if (dec_tally == reg_ppo) begin
        dec_tally = '0;
        if (room != 0) begin
          dec_store[dec_count[5:0]] = 1'b1;
          dec_count = dec_count + 1'b1;
        end
      end
    end else begin
      if (reg_slot == 0) begin
        zeros = 64'(room);
      end else begin
        zeros = (64'(gap) * 2 + 64'(reg_slot)) / (64'(reg_slot) * 2);
        if (zeros > 64'(room)) zeros = 64'(room);
      end
      dec_count = dec_count + zeros[LEN_W-1:0];
    end
    dec_last_time = now;
    if (dec_count == 2 && dec_store[1:0] != 2'b01) begin
      dec_count = '0;
      dec_store = '0;
      r.header_rejected = 1'b1;
    end
    r.message_done = (dec_count >= eff_len);
    if (r.message_done) dec_done_seen = 1'b1;
    r.bits_held = dec_count;
    r.message_bits = dec_store;
    pending_results.push_back(r);
  endfunction

  task automatic send_edge(input logic [TIME_W-1:0] t);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edge_clock = t;
    items_sent++;
    decode_edge(t);
  endtask

  task automatic send_gap(input logic [TIME_W-1:0] gap);
    send_edge(edge_clock + gap);
  endtask

  task automatic send_symbol(input bit one);
    int unsigned g;
    int unsigned n;
    if (one && reg_burst_gap != 0) begin
      repeat ((reg_ppo == 0) ? 256 : int'(reg_ppo))
        send_gap($urandom_range(0, int'(reg_burst_gap) - 1));
    end else begin
      n = $urandom_range(1, 3);
      if (reg_slot == 0) begin
        g = int'(reg_burst_gap) + $urandom_range(0, 5000);
      end else begin
        g = n * reg_slot + $urandom_range(0, int'(reg_slot)) - reg_slot / 2;
        if (g < reg_burst_gap) g = reg_burst_gap;
      end
      send_gap(g);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [BURST_W-1:0] burst, input logic [SLOT_W-1:0] slot,
                              input logic [PPO_W-1:0] ppo, input logic [LEN_W-1:0] len);
    logic [7:0] junk_ppo;
    logic [8:0] junk_len;
    junk_ppo = $urandom;
    junk_len = $urandom;
    wait_idle();
    put_reg(REG_BURST_GAP, burst);
    put_reg(REG_SLOT, slot);
    put_reg(REG_PPO, {junk_ppo, ppo});
    put_reg(REG_MSG_LEN, {junk_len, len});
    cfg_wr_en <= 1'b0;
    reg_burst_gap = burst;
    reg_slot = slot;
    reg_ppo = ppo;
    reg_msg_len = len;
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned noise_pct);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1)) send_edge($urandom);
        else send_gap($urandom_range(0, 4 * int'(reg_slot) + 100));
      end else if (dec_done_seen || dec_count == 0) begin
        send_symbol($urandom_range(0, 99) < 85);
      end else if (dec_count == 1) begin
        send_symbol($urandom_range(0, 99) < 20);
      end else begin
        send_symbol($urandom_range(0, 1));
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_edge(32'd0);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'd5);
  endtask

  task automatic test_bit_decoding();
    apply_config(16'd100, 16'd1000, 8'd1, 7'd4);
    send_gap(10);
    send_gap(1000);
    send_gap(10);
    send_gap(10);
    send_gap(10);
    send_gap(99);
    send_gap(1500);
    send_gap(500);
    send_gap(499);
    send_gap(100);
    send_gap(10);
  endtask

  task automatic test_length_change();
    apply_config(16'd100, 16'd1000, 8'd1, 7'd8);
    send_gap(10);
    send_gap(3000);
    send_gap(2000);
    apply_config(16'd100, 16'd1000, 8'd1, 7'd3);
    send_gap(10);
    send_gap(5);
  endtask

  task automatic test_slot_zero_and_clamp();
    apply_config(16'd100, 16'd0, 8'd1, 7'd1);
    send_gap(10);
    send_gap(200);
    apply_config(16'd100, 16'd0, 8'd1, 7'd127);
    send_gap(10);
    send_gap(200);
  endtask

  task automatic test_random_messages();
    apply_config(16'd40, 16'd200, 8'd2, 7'd10);
    run_phase(300, 10);
    apply_config(16'd1, 16'd1, 8'd1, 7'd64);
    run_phase(150, 10);
    apply_config(16'hFFFF, 16'hFFFF, 8'd255, 7'd2);
    run_phase(100, 5);
  endtask

  task automatic test_pulse_wrap();
    apply_config(16'd300, 16'd0, 8'd0, 7'd0);
    run_phase(100, 5);
  endtask

  task automatic test_noise();
    apply_config(16'd0, 16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                 7'($urandom_range(65, 127)));
    run_phase(100, 100);
  endtask

  task automatic test_steady_stream();
    apply_config(16'($urandom_range(10, 500)), 16'($urandom_range(600, 3000)),
                 8'($urandom_range(1, 4)), 7'($urandom_range(2, 64)));
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    run_phase(250, 10);
  endtask

  task automatic check_result();
    slot_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected item: bits_held %0d message_bits %h", out_bits_held, out_message_bits);
      failed = 1'b1;
    end else begin
      exp_r = pending_results.pop_front();
      if (out_bits_held !== exp_r.bits_held) begin
        $error("bits_held expected %0d got %0d", exp_r.bits_held, out_bits_held);
        failed = 1'b1;
      end
      if (out_message_bits !== exp_r.message_bits) begin
        $error("message_bits expected %h got %h", exp_r.message_bits, out_message_bits);
        failed = 1'b1;
      end
      if (out_message_done !== exp_r.message_done) begin
        $error("message_done expected %0b got %0b", exp_r.message_done, out_message_done);
        failed = 1'b1;
      end
      if (out_header_rejected !== exp_r.header_rejected) begin
        $error("header_rejected expected %0b got %0b", exp_r.header_rejected,
               out_header_rejected);
        failed = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_bit_decoding();
    test_length_change();
    test_slot_zero_and_clamp();
    test_random_messages();
    test_pulse_wrap();
    test_noise();
    test_steady_stream();
    wait_idle();
    if (!failed && pending_results.size() == 0) begin
      $display("[ir_pulse_slot_decoder] OK");
    end else begin
      $display("[ir_pulse_slot_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[ir_pulse_slot_decoder] ERROR");
    $finish;
  end

endmodule
